/* rtl/plp_pkg.sv */
// ----------------------------------------------------------------------------
// plp_pkg
// shared constants for the positional list: operation and status codes,
// stream field widths
// ----------------------------------------------------------------------------
package plp_pkg;

    // operation codes carried on s_tuser
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SHOW   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // field widths
    localparam int OP_W   = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int SIZE_W = 5;

    // stream widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

endpackage

/* rtl/positional_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// ordered list of signed 32-bit values with insert and remove at a position,
// show and clear; entries live in a small ram moved one per step
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one item per operation, s_tuser holds the op code,
//   s_tdata holds position and value. output channel m_*: result items,
//   m_tlast marks the final result of an operation, m_tuser flags a list
//   entry on m_tdata during show.
// sequencing and throughput
//   the block takes one item at a time; s_tready is high only while idle.
//   insert shifts the entries from the top down to the position, one per
//   read/write pair, then places the value; remove shifts those above the
//   position down alike. removing the last entry, clear, show of an empty
//   list and refused ops go straight to the result; show reads and emits
//   each entry; the single ram port pair and registered read set the cost.
// reset
//   rst_n clears the count, the sequencer and the output valid; the ram is
//   not cleared, entries at or above the count are never read.
// stalls
//   a result sits in the output register until m_tready; the sequencer
//   waits at its result step while the register is still occupied.
// ----------------------------------------------------------------------------
module positional_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [plp_pkg::S_DATA_W-1:0] s_tdata,  // position[4:0], value[36:5], zero[39:37]
    input  logic [plp_pkg::OP_W-1:0]     s_tuser,  // op[1:0]
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [plp_pkg::M_DATA_W-1:0] m_tdata,  // status[1:0], element_out[33:2],
                                                   // size_now[38:34], is_empty[39]
    output logic                         m_tuser,  // has_value
    output logic                         m_tlast   // last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > plp_pkg::POS_W) ? CW : plp_pkg::POS_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;  // read neighbor entry
    localparam logic [2:0] S_WR    = 3'd2;  // write it one place over
    localparam logic [2:0] S_PUT   = 3'd3;  // place the inserted value
    localparam logic [2:0] S_RES   = 3'd4;  // emit single result
    localparam logic [2:0] S_SRD   = 3'd5;  // show: read entry
    localparam logic [2:0] S_SOUT  = 3'd6;  // show: emit entry

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [plp_pkg::OP_W-1:0]       op_reg, op_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [plp_pkg::VAL_W-1:0]      val_reg, val_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  lim_reg, lim_next;
    logic [plp_pkg::ST_W-1:0]       res_reg, res_next;

    // output register
    logic                           ovalid_reg, ovalid_next;
    logic [plp_pkg::M_DATA_W-1:0]   odata_reg, odata_next;
    logic                           ouser_reg, ouser_next;
    logic                           olast_reg, olast_next;

    // input fields
    logic [plp_pkg::OP_W-1:0]       in_op;
    logic [plp_pkg::POS_W-1:0]      in_pos;
    logic [plp_pkg::VAL_W-1:0]      in_val;
    logic [XW-1:0]                  pos_x;
    logic [XW-1:0]                  cnt_x;
    logic                           accept;
    logic                           out_free;

    // ram and step unit hookup
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [plp_pkg::VAL_W-1:0]      ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [plp_pkg::VAL_W-1:0]      ram_rdata;
    logic                           step_up;
    logic [CW-1:0]                  step_sum;
    logic                           step_hit;

    assign in_op  = s_tuser;
    assign in_pos = s_tdata[plp_pkg::POS_W-1:0];
    assign in_val = s_tdata[plp_pkg::POS_W +: plp_pkg::VAL_W];
    assign pos_x  = XW'(in_pos);
    assign cnt_x  = XW'(count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;

    // insert walks down, remove and show walk up
    assign step_up = (op_reg != plp_pkg::OP_INSERT);

    plp_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plp_step #(
        .AW (AW),
        .CW (CW)
    ) u_step (
        .idx (idx_reg),
        .up  (step_up),
        .lim (lim_reg),
        .sum (step_sum),
        .hit (step_hit)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = step_sum[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    val_next = in_val;
                    pos_next = pos_x[AW-1:0];
                    res_next = plp_pkg::ST_OK;
                    unique case (in_op)
                        plp_pkg::OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_next   = plp_pkg::ST_FULL;
                                state_next = S_RES;
                            end
                            else if (pos_x > cnt_x)
                            begin
                                res_next   = plp_pkg::ST_RANGE;
                                state_next = S_RES;
                            end
                            else
                            begin
                                // shift from the top down to the position
                                idx_next   = count_reg[AW-1:0];
                                lim_next   = pos_x[CW-1:0];
                                state_next = (pos_x == cnt_x) ? S_PUT : S_RD;
                            end
                        end
                        plp_pkg::OP_REMOVE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                // also covers the empty list
                                res_next   = plp_pkg::ST_RANGE;
                                state_next = S_RES;
                            end
                            else if (pos_x + XW'(1) == cnt_x)
                            begin
                                // removing the last entry moves nothing
                                count_next = count_reg - CW'(1);
                                state_next = S_RES;
                            end
                            else
                            begin
                                idx_next   = pos_x[AW-1:0];
                                lim_next   = count_reg - CW'(1);
                                state_next = S_RD;
                            end
                        end
                        plp_pkg::OP_SHOW:
                        begin
                            idx_next   = '0;
                            lim_next   = count_reg;
                            state_next = (count_reg == '0) ? S_RES : S_SRD;
                        end
                        default:
                        begin
                            count_next = '0;
                            state_next = S_RES;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_we   = 1'b1;
                idx_next = step_sum[AW-1:0];
                if (op_reg == plp_pkg::OP_INSERT)
                begin
                    state_next = step_hit ? S_PUT : S_RD;
                end
                else if (step_hit)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RES;
            end
            S_RES:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {(count_reg == '0), cnt_x[plp_pkg::SIZE_W-1:0],
                                   {plp_pkg::VAL_W{1'b0}}, res_reg};
                    ouser_next  = 1'b0;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = S_SOUT;
            end
            S_SOUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {(count_reg == '0), cnt_x[plp_pkg::SIZE_W-1:0],
                                   ram_rdata, plp_pkg::ST_OK};
                    ouser_next  = 1'b1;
                    olast_next  = step_hit;
                    idx_next    = step_sum[AW-1:0];
                    state_next  = step_hit ? S_IDLE : S_SRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        lim_reg   <= lim_next;
        res_reg   <= res_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

/* rtl/plp_ram.sv */
// ----------------------------------------------------------------------------
// plp_ram
// entry storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module plp_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [plp_pkg::VAL_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [plp_pkg::VAL_W-1:0] rdata
);

    logic [plp_pkg::VAL_W-1:0] mem [DEPTH];
    logic [plp_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/plp_step.sv */
// ----------------------------------------------------------------------------
// plp_step
// shared index unit: steps an entry index up or down by one and compares
// the stepped index against a limit
// ----------------------------------------------------------------------------
module plp_step #(
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic [AW-1:0] idx,
    input  logic          up,
    input  logic [CW-1:0] lim,
    output logic [CW-1:0] sum,
    output logic          hit
);

    logic [CW-1:0] idx_x;

    assign idx_x = CW'(idx);
    assign sum   = up ? (idx_x + CW'(1)) : (idx_x - CW'(1));
    assign hit   = (sum == lim);

endmodule

/* verif/tb_positional_list_insert_remove.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_insert_remove
// self-checking bench for the positional list: a mirror list in the bench
// predicts every result item of insert, remove, show and clear, a checker
// compares each result item field by field, and both stream sides idle at
// random, with one long output hold-off that fills the block up
// ----------------------------------------------------------------------------
module tb_positional_list_insert_remove;

    localparam int LIST_CAP     = 16;
    localparam int MAX_POS      = 16;         // position equal to the list capacity
    localparam int DRAIN_CYCLES = 80;         // beyond the longest insert/remove walk
    localparam int DRAIN_LIMIT  = 60000;
    localparam int RANDOM_ITEMS = 120;

    // one expected result item
    typedef struct {
        logic [plp_pkg::ST_W-1:0]   status;
        logic                       has_value;
        logic [plp_pkg::VAL_W-1:0]  element;
        logic [plp_pkg::SIZE_W-1:0] size_now;
        logic                       is_empty;
        logic                       last;
    } list_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [plp_pkg::S_DATA_W-1:0] s_tdata = '0;    // position[4:0], value[36:5], zero[39:37]
    logic [plp_pkg::OP_W-1:0]     s_tuser = '0;    // op[1:0]
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [plp_pkg::M_DATA_W-1:0] m_tdata;         // status[1:0], element_out[33:2],
                                                   // size_now[38:34], is_empty[39]
    logic                         m_tuser;         // has_value
    logic                         m_tlast;         // last

    // mirror of the list contents, updated when an item is accepted
    logic [plp_pkg::VAL_W-1:0]    mirror_entries [LIST_CAP];
    int                           mirror_count;
    list_result_t                 pending_results [$];

    int                           err_count;
    bit                           tx_idle_en;
    bit                           rx_idle_en;
    int                           long_hold_req;   // cycles the receiver should hold off

    positional_list_insert_remove #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 30)
            $display("error @%0t: %s", $realtime, msg);
    endtask

    // queue one expected result item; size and empty flag follow the mirror
    function automatic void push_result(input logic [plp_pkg::ST_W-1:0] status,
                                        input logic has_value,
                                        input logic [plp_pkg::VAL_W-1:0] element,
                                        input logic last);
        list_result_t r;
        r.status    = status;
        r.has_value = has_value;
        r.element   = element;
        r.size_now  = plp_pkg::SIZE_W'(mirror_count);
        r.is_empty  = (mirror_count == 0);
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    // apply one accepted item to the mirror list and queue its result items
    function automatic void apply_list_op(input logic [plp_pkg::OP_W-1:0] op,
                                          input logic [plp_pkg::POS_W-1:0] pos,
                                          input logic [plp_pkg::VAL_W-1:0] val);
        int p;
        p = int'(pos);
        case (op)
            plp_pkg::OP_INSERT:
            begin
                // fullness wins over a bad position
                if (mirror_count >= LIST_CAP)
                    push_result(plp_pkg::ST_FULL, 1'b0, '0, 1'b1);
                else if (p > mirror_count)
                    push_result(plp_pkg::ST_RANGE, 1'b0, '0, 1'b1);
                else
                begin
                    for (int i = mirror_count; i > p; i--)
                        mirror_entries[i] = mirror_entries[i - 1];
                    mirror_entries[p] = val;
                    mirror_count++;
                    push_result(plp_pkg::ST_OK, 1'b0, '0, 1'b1);
                end
            end
            plp_pkg::OP_REMOVE:
            begin
                if (mirror_count == 0 || p >= mirror_count)
                    push_result(plp_pkg::ST_RANGE, 1'b0, '0, 1'b1);
                else
                begin
                    for (int i = p; i + 1 < mirror_count; i++)
                        mirror_entries[i] = mirror_entries[i + 1];
                    mirror_count--;
                    push_result(plp_pkg::ST_OK, 1'b0, '0, 1'b1);
                end
            end
            plp_pkg::OP_SHOW:
            begin
                // an empty list still answers with a single empty marker
                if (mirror_count == 0)
                    push_result(plp_pkg::ST_OK, 1'b0, '0, 1'b1);
                else
                    for (int i = 0; i < mirror_count; i++)
                        push_result(plp_pkg::ST_OK, 1'b1, mirror_entries[i],
                                    i + 1 == mirror_count);
            end
            default:
            begin
                mirror_count = 0;
                push_result(plp_pkg::ST_OK, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    // offer one item, wait for the handshake, then predict its results.
    // valid stays high into the next item unless a gap is wanted
    task automatic send_item(input logic [plp_pkg::OP_W-1:0] op,
                             input logic [plp_pkg::POS_W-1:0] pos,
                             input logic [plp_pkg::VAL_W-1:0] val);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, val, pos};
        do
            @(posedge clk);
        while (!s_tready);
        apply_list_op(op, pos, val);
    endtask

    // receiver: random stalls, plus a long hold-off when a test asks for one
    initial
    begin : result_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_req > 0)
            begin
                hold_left     = long_hold_req - 1;
                long_hold_req = 0;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // checker: every accepted result item against the oldest expectation
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("result item with nothing expected, tdata %0h",
                                       m_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_error($sformatf("status got %0d want %0d",
                                           m_tdata[1:0], want.status));
                if (m_tuser !== want.has_value)
                    report_error($sformatf("has_value got %0b want %0b",
                                           m_tuser, want.has_value));
                if (m_tdata[33:2] !== want.element)
                    report_error($sformatf("element_out got %0h want %0h",
                                           m_tdata[33:2], want.element));
                if (m_tdata[38:34] !== want.size_now)
                    report_error($sformatf("size_now got %0d want %0d",
                                           m_tdata[38:34], want.size_now));
                if (m_tdata[39] !== want.is_empty)
                    report_error($sformatf("is_empty got %0b want %0b",
                                           m_tdata[39], want.is_empty));
                if (m_tlast !== want.last)
                    report_error($sformatf("last got %0b want %0b", m_tlast, want.last));
            end
        end
    end

    // every op against an empty list, including position MAX_POS
    task automatic test_empty_list();
        send_item(plp_pkg::OP_SHOW, 5'd0, $urandom);
        send_item(plp_pkg::OP_REMOVE, 5'd0, $urandom);
        send_item(plp_pkg::OP_INSERT, 5'd1, $urandom);           // beyond count
        send_item(plp_pkg::OP_INSERT, 5'(MAX_POS), $urandom);
        send_item(plp_pkg::OP_CLEAR, 5'(MAX_POS), $urandom);
    endtask

    // inserts at front, middle and end with extreme values, then removes
    // at end, middle and front, and a clear that empties a live list
    task automatic test_shift_ops();
        send_item(plp_pkg::OP_INSERT, 5'd0, 32'h7fff_ffff);
        send_item(plp_pkg::OP_INSERT, 5'd1, 32'h8000_0000);    // append
        send_item(plp_pkg::OP_INSERT, 5'd0, 32'hffff_ffff);    // front
        send_item(plp_pkg::OP_INSERT, 5'd2, 32'h0000_0000);    // middle
        send_item(plp_pkg::OP_SHOW, 5'd0, $urandom);
        send_item(plp_pkg::OP_REMOVE, 5'd4, $urandom);         // position equal to count
        send_item(plp_pkg::OP_REMOVE, 5'd3, $urandom);         // last entry
        send_item(plp_pkg::OP_REMOVE, 5'd1, $urandom);         // middle
        send_item(plp_pkg::OP_REMOVE, 5'd0, $urandom);         // front
        send_item(plp_pkg::OP_SHOW, 5'd0, $urandom);
        send_item(plp_pkg::OP_INSERT, 5'd3, $urandom);         // past the end
        send_item(plp_pkg::OP_INSERT, 5'd1, 32'h5555_aaaa);
        send_item(plp_pkg::OP_CLEAR, 5'd0, $urandom);
        send_item(plp_pkg::OP_SHOW, 5'd0, $urandom);
    endtask

    // fill the list to capacity while the receiver holds off, so the
    // output register backs up and the block stops taking items
    task automatic test_full_list_backpressure();
        tx_idle_en    = 1'b0;
        long_hold_req = 400;
        while (mirror_count < LIST_CAP)
            send_item(plp_pkg::OP_INSERT, 5'($urandom_range(0, mirror_count)), $urandom);
        send_item(plp_pkg::OP_INSERT, 5'd0, $urandom);         // full, any position
        send_item(plp_pkg::OP_INSERT, 5'(MAX_POS), $urandom);
        send_item(plp_pkg::OP_INSERT, 5'd31, $urandom);        // all position bits high
        send_item(plp_pkg::OP_SHOW, 5'd0, $urandom);
        send_item(plp_pkg::OP_REMOVE, 5'(MAX_POS), $urandom);  // one past the last entry
        send_item(plp_pkg::OP_REMOVE, 5'd15, $urandom);
        send_item(plp_pkg::OP_INSERT, 5'(LIST_CAP - 1), $urandom);
        send_item(plp_pkg::OP_SHOW, 5'd0, $urandom);
    endtask

    // mostly well-formed ops on the live list, some out of range, a little noise
    task automatic test_random_ops(input int n_items);
        int r;
        for (int k = 0; k < n_items; k++)
        begin
            // change idling behavior in stretches, some with none at all
            if (k % 20 == 0)
            begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(plp_pkg::OP_INSERT,
                          5'(r < 40 ? $urandom_range(0, mirror_count)
                                    : $urandom_range(0, MAX_POS)),
                          $urandom);
            else if (r < 70)
                send_item(plp_pkg::OP_REMOVE,
                          5'((r < 64 && mirror_count > 0) ? $urandom_range(0, mirror_count - 1)
                                                          : $urandom_range(0, MAX_POS)),
                          $urandom);
            else if (r < 85)
                send_item(plp_pkg::OP_SHOW, 5'($urandom_range(0, MAX_POS)), $urandom);
            else if (r < 90)
                send_item(plp_pkg::OP_CLEAR, 5'($urandom_range(0, MAX_POS)), $urandom);
            else
                send_item(plp_pkg::OP_W'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                          $urandom);
        end
    endtask

    initial
    begin
        int guard;
        err_count     = 0;
        mirror_count  = 0;
        long_hold_req = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        guard         = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_shift_ops();
        test_full_list_backpressure();
        test_random_ops(RANDOM_ITEMS);
        s_tvalid <= 1'b0;

        // drain what is still owed, then watch for stray result items
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d result items never arrived",
                                   pending_results.size()));

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
